// ----- rtl/mdp_pkg.sv -----
// ============================================================================
// mdp_pkg - shared types and constants for the motor drive protection block
// command codes, latch reasons, buzzer actions, register indexes and widths
// ============================================================================
package mdp_pkg;

    localparam int NUM_MOTORS = 2;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DUTY          = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STALL_DRIVE_LEVEL = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STALL_SPEED_LEVEL = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STALL_TICKS       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_LIMIT       = 3'd4;

    // register reset values
    localparam logic [14:0] MAX_DUTY_RST          = 15'd10000;
    localparam logic [14:0] STALL_DRIVE_LEVEL_RST = 15'd5000;
    localparam logic [15:0] STALL_SPEED_LEVEL_RST = 16'd10;
    localparam logic [15:0] STALL_TICKS_RST       = 16'd500;
    localparam logic [14:0] ANGLE_LIMIT_RST       = 15'd4500;

    // beat layout
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;

    typedef enum logic [1:0] {
        CMD_DRIVE  = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_ENABLE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        LATCH_NONE  = 2'd0,
        LATCH_STALL = 2'd1,
        LATCH_PITCH = 2'd2
    } latch_t;

    typedef enum logic [1:0] {
        BUZ_NONE  = 2'd0,
        BUZ_START = 2'd1,
        BUZ_STOP  = 2'd2
    } buzzer_t;

    // stall detection thresholds shared by the per-motor units
    typedef struct packed {
        logic [14:0] drive_level;
        logic [15:0] speed_level;
        logic [15:0] ticks;
    } stall_cfg_t;

endpackage

// ----- rtl/mdp_stall_unit.sv -----
// ============================================================================
// mdp_stall_unit - per-motor stall counter step
// counts consecutive ticks of high remembered drive with low encoder speed
// ============================================================================
module mdp_stall_unit #(
    parameter int COUNT_BITS = 16
) (
    input  logic                    active,      // tick with no motor latched
    input  logic signed [15:0]      last_drive,
    input  logic signed [15:0]      speed,
    input  mdp_pkg::stall_cfg_t     cfg,
    input  logic [COUNT_BITS-1:0]   count_cur,
    output logic [COUNT_BITS-1:0]   count_new,
    output logic                    stall_hit
);

    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [16:0]           drive_mag;
    logic [16:0]           speed_mag;
    logic signed [16:0]    drive_ext;
    logic signed [16:0]    speed_ext;
    logic                  stalled;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  reached;

    // magnitudes on 17 bits so the most negative value needs no special case
    assign drive_ext = {last_drive[15], last_drive};
    assign speed_ext = {speed[15], speed};
    assign drive_mag = drive_ext[16] ? 17'(-drive_ext) : 17'(drive_ext);
    assign speed_mag = speed_ext[16] ? 17'(-speed_ext) : 17'(speed_ext);

    assign stalled = (drive_mag > {2'b00, cfg.drive_level})
                  && (speed_mag < {1'b0, cfg.speed_level});

    // saturating increment
    assign count_inc = (&count_cur) ? count_cur : count_cur + 1'b1;
    assign reached   = CMP_W'(count_inc) >= CMP_W'(cfg.ticks);

    assign stall_hit = active && stalled && reached;

    always_comb begin
        if (!active) begin
            count_new = count_cur;
        end else if (!stalled || reached) begin
            count_new = '0;
        end else begin
            count_new = count_inc;
        end
    end

endmodule

// ----- rtl/motor_drive_protection.sv -----
// ============================================================================
// motor_drive_protection - two-motor drive guard with stall and pitch latches
// turns drive requests into duty/direction writes and runs protection ticks
// ============================================================================
// Each input beat is one command (tuser): drive request, protection tick,
// clear protection or set enable, and produces exactly one result beat.
// A beat is captured in an input register, evaluated by one pass of
// compare/clamp/count logic and stored in the output register, and one
// beat can be accepted every cycle while the result side takes beats.
// The input register and the output register each hold one beat, so a
// new beat is still accepted while a finished result waits on m_tready.
// A drive request is clamped to +-max_duty and gives zero duty while
// disabled or while its motor is latched. A tick latches motor 0 on the
// rising edge of a pitch excursion beyond angle_limit, then (if nothing
// is latched) counts stalled ticks per motor and latches at stall_ticks.
// Any latch drops the enable, stops both motors and starts the alarm
// unless the buzzer is busy. Configuration registers must be written
// only while no beat is in flight.
module motor_drive_protection #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [mdp_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [mdp_pkg::CFG_DATA_W-1:0]        cfg_wdata,

    // command beats
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // drive_request[15:0], speed_motor0[31:16], speed_motor1[47:32],
    // pitch_angle[63:48], buzzer_busy[64], enable_value[65], zeros above
    input  logic [mdp_pkg::S_TDATA_W-1:0]         s_tdata,
    // command[1:0], motor_sel[2]
    input  logic [mdp_pkg::S_TUSER_W-1:0]         s_tuser,

    // result beats
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // duty_write[0], duty_value[15:1], dir_write[16], dir_level[17],
    // stop_all[18], buzzer_action[20:19], clear_integrals[21],
    // status_motor0[23:22], status_motor1[25:24], enable_now[26], zeros above
    output logic [mdp_pkg::M_TDATA_W-1:0]         m_tdata,
    // duty_motor[0]
    output logic [mdp_pkg::M_TUSER_W-1:0]         m_tuser
);

    localparam int NM = mdp_pkg::NUM_MOTORS;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [14:0] max_duty_reg;
    logic [14:0] stall_drive_level_reg;
    logic [15:0] stall_speed_level_reg;
    logic [15:0] stall_ticks_reg;
    logic [14:0] angle_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_duty_reg          <= mdp_pkg::MAX_DUTY_RST;
            stall_drive_level_reg <= mdp_pkg::STALL_DRIVE_LEVEL_RST;
            stall_speed_level_reg <= mdp_pkg::STALL_SPEED_LEVEL_RST;
            stall_ticks_reg       <= mdp_pkg::STALL_TICKS_RST;
            angle_limit_reg       <= mdp_pkg::ANGLE_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mdp_pkg::REG_MAX_DUTY:          max_duty_reg <= cfg_wdata[14:0];
                mdp_pkg::REG_STALL_DRIVE_LEVEL: stall_drive_level_reg <= cfg_wdata[14:0];
                mdp_pkg::REG_STALL_SPEED_LEVEL: stall_speed_level_reg <= cfg_wdata;
                mdp_pkg::REG_STALL_TICKS:       stall_ticks_reg <= cfg_wdata;
                mdp_pkg::REG_ANGLE_LIMIT:       angle_limit_reg <= cfg_wdata[14:0];
                default: begin
                    // unused indexes are ignored
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: input register feeding the output register
    // ------------------------------------------------------------------
    logic               in_valid_reg;
    logic               m_valid_reg;
    logic               out_free;     // output register can take a result
    logic               fire;         // evaluate the captured beat this cycle
    logic               s_accept;

    assign out_free = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // captured beat payload
    mdp_pkg::cmd_t      cmd_reg;
    logic               sel_reg;
    logic signed [15:0] request_reg;
    logic signed [15:0] speed_reg [NM];
    logic signed [15:0] pitch_reg;
    logic               busy_reg;
    logic               enable_value_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg          <= mdp_pkg::cmd_t'(s_tuser[1:0]);
            sel_reg          <= s_tuser[2];
            request_reg      <= s_tdata[15:0];
            speed_reg[0]     <= s_tdata[31:16];
            speed_reg[1]     <= s_tdata[47:32];
            pitch_reg        <= s_tdata[63:48];
            busy_reg         <= s_tdata[64];
            enable_value_reg <= s_tdata[65];
        end
    end

    // ------------------------------------------------------------------
    // protection state
    // ------------------------------------------------------------------
    logic                    enable_reg,     enable_next;
    logic                    armed_reg,      armed_next;
    logic signed [15:0]      last_drive_reg [NM];
    logic signed [15:0]      last_drive_next [NM];
    logic [COUNT_BITS-1:0]   count_reg [NM];
    logic [COUNT_BITS-1:0]   count_next [NM];
    mdp_pkg::latch_t         latch_reg [NM];
    mdp_pkg::latch_t         latch_next [NM];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            armed_reg  <= 1'b0;
            for (int i = 0; i < NM; i++) begin
                last_drive_reg[i] <= '0;
                count_reg[i]      <= '0;
                latch_reg[i]      <= mdp_pkg::LATCH_NONE;
            end
        end else if (fire) begin
            enable_reg <= enable_next;
            armed_reg  <= armed_next;
            for (int i = 0; i < NM; i++) begin
                last_drive_reg[i] <= last_drive_next[i];
                count_reg[i]      <= count_next[i];
                latch_reg[i]      <= latch_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // drive request: clamp to +-max_duty, split into magnitude and direction
    // ------------------------------------------------------------------
    logic signed [16:0] req_ext;
    logic signed [16:0] lim_pos;
    logic signed [16:0] lim_neg;
    logic signed [16:0] clamped;
    logic [16:0]        clamped_mag;
    logic               drive_ok;

    assign req_ext = {request_reg[15], request_reg};
    assign lim_pos = {2'b00, max_duty_reg};
    assign lim_neg = -lim_pos;

    always_comb begin
        priority if (req_ext > lim_pos) begin
            clamped = lim_pos;
        end else if (req_ext < lim_neg) begin
            clamped = lim_neg;
        end else begin
            clamped = req_ext;
        end
    end

    assign clamped_mag = clamped[16] ? 17'(-clamped) : 17'(clamped);
    assign drive_ok    = enable_reg && (latch_reg[sel_reg] == mdp_pkg::LATCH_NONE);

    // ------------------------------------------------------------------
    // pitch check, edge armed: one latch per excursion
    // ------------------------------------------------------------------
    logic signed [16:0] pitch_ext;
    logic [16:0]        pitch_mag;
    logic               pitch_over;
    logic               pitch_trip;
    mdp_pkg::latch_t    latch0_after_pitch;

    assign pitch_ext  = {pitch_reg[15], pitch_reg};
    assign pitch_mag  = pitch_ext[16] ? 17'(-pitch_ext) : 17'(pitch_ext);
    assign pitch_over = pitch_mag > {2'b00, angle_limit_reg};
    assign pitch_trip = (cmd_reg == mdp_pkg::CMD_TICK) && pitch_over && !armed_reg;

    assign latch0_after_pitch = pitch_trip ? mdp_pkg::LATCH_PITCH : latch_reg[0];

    // ------------------------------------------------------------------
    // stall counting, only when no motor is latched after the pitch check
    // ------------------------------------------------------------------
    mdp_pkg::stall_cfg_t   stall_cfg;
    logic                  stall_active;
    logic [COUNT_BITS-1:0] count_step [NM];
    logic [NM-1:0]         stall_hit;

    assign stall_cfg.drive_level = stall_drive_level_reg;
    assign stall_cfg.speed_level = stall_speed_level_reg;
    assign stall_cfg.ticks       = stall_ticks_reg;

    assign stall_active = (cmd_reg == mdp_pkg::CMD_TICK)
                       && (latch0_after_pitch == mdp_pkg::LATCH_NONE)
                       && (latch_reg[1] == mdp_pkg::LATCH_NONE);

    for (genvar g = 0; g < NM; g++) begin : g_stall
        mdp_stall_unit #(
            .COUNT_BITS (COUNT_BITS)
        ) u_stall (
            .active     (stall_active),
            .last_drive (last_drive_reg[g]),
            .speed      (speed_reg[g]),
            .cfg        (stall_cfg),
            .count_cur  (count_reg[g]),
            .count_new  (count_step[g]),
            .stall_hit  (stall_hit[g])
        );
    end

    // ------------------------------------------------------------------
    // next state and result
    // ------------------------------------------------------------------
    logic               any_latch;
    logic               duty_write;
    logic [14:0]        duty_value;
    logic               dir_write;
    logic               dir_level;
    mdp_pkg::buzzer_t   buzzer_action;

    assign any_latch = pitch_trip || (|stall_hit);

    always_comb begin
        enable_next   = enable_reg;
        armed_next    = armed_reg;
        duty_write    = 1'b0;
        duty_value    = '0;
        dir_write     = 1'b0;
        dir_level     = 1'b0;
        buzzer_action = mdp_pkg::BUZ_NONE;
        for (int i = 0; i < NM; i++) begin
            last_drive_next[i] = last_drive_reg[i];
            count_next[i]      = count_reg[i];
            latch_next[i]      = latch_reg[i];
        end

        unique case (cmd_reg)
            mdp_pkg::CMD_DRIVE: begin
                duty_write = 1'b1;
                if (drive_ok) begin
                    duty_value = clamped_mag[14:0];
                    dir_write  = 1'b1;
                    dir_level  = !clamped[16];
                    last_drive_next[sel_reg] = clamped[15:0];
                end
            end
            mdp_pkg::CMD_TICK: begin
                armed_next    = pitch_over;
                latch_next[0] = latch0_after_pitch;
                for (int i = 0; i < NM; i++) begin
                    count_next[i] = count_step[i];
                    if (stall_hit[i]) begin
                        latch_next[i] = mdp_pkg::LATCH_STALL;
                    end
                end
                if (any_latch) begin
                    enable_next = 1'b0;
                    if (!busy_reg) begin
                        buzzer_action = mdp_pkg::BUZ_START;
                    end
                end
            end
            mdp_pkg::CMD_CLEAR: begin
                for (int i = 0; i < NM; i++) begin
                    latch_next[i] = mdp_pkg::LATCH_NONE;
                    count_next[i] = '0;
                end
                buzzer_action = mdp_pkg::BUZ_STOP;
            end
            mdp_pkg::CMD_ENABLE: begin
                enable_next = enable_value_reg;
            end
            default: begin
                // all command codes are covered above
            end
        endcase
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [mdp_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [mdp_pkg::M_TUSER_W-1:0] m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= {5'd0,
                            enable_next,
                            latch_next[1],
                            latch_next[0],
                            pitch_trip,
                            buzzer_action,
                            (cmd_reg == mdp_pkg::CMD_TICK) && any_latch,
                            dir_level,
                            dir_write,
                            duty_value,
                            duty_write};
            // motor select only means something on a drive beat
            m_tuser_reg <= (cmd_reg == mdp_pkg::CMD_DRIVE) ? sel_reg : 1'b0;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

`ifndef SYNTHESIS
    // no latch may leave the block enabled
    a_latch_disables: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_tdata_reg[18]) |-> !m_tdata_reg[26])
        else $error("stop_all with enable_now set");

    // an integrator reset only comes with a pitch latch on motor 0
    a_pitch_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_tdata_reg[21])
            |-> (m_tdata_reg[23:22] == mdp_pkg::LATCH_PITCH) && m_tdata_reg[18])
        else $error("clear_integrals without pitch latch");

    // a new result beat only comes from an evaluated command beat
    a_out_from_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(in_valid_reg))
        else $error("result beat without captured command");

    // motor 1 never carries a pitch latch
    a_motor1_no_pitch: assert property (@(posedge aclk) disable iff (!aresetn)
        latch_reg[1] != mdp_pkg::LATCH_PITCH)
        else $error("motor 1 latched for pitch");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid_reg && !in_valid_reg))
        else $error("beats survive reset");
`endif

endmodule
